// ----- hw/rtl/gbpt_pkg.sv -----
// Shared types and constants of the greedy byte-pair tokenizer.
package gbpt_pkg;

    // Field and bus widths.
    localparam int BYTE_W     = 8;
    localparam int PAIR_W     = 2 * BYTE_W;
    localparam int TOKEN_W    = 9;
    localparam int COUNT_W    = 9;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // Output queue geometry.
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    // Item kinds carried on the input tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // Merged tokens are numbered after the raw byte values.
    localparam logic [TOKEN_W-1:0] MERGE_BASE = 9'd256;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic [TOKEN_W-1:0] id;
        logic               last;
    } t_token;

    // Up to two tokens are produced in one cycle; push1 only comes with push0.
    typedef struct packed {
        logic   push0;
        logic   push1;
        t_token tok0;
        t_token tok1;
    } t_push;

endpackage

// ----- hw/rtl/greedy_byte_pair_tokenizer_top.sv -----
// Top level of the greedy byte-pair tokenizer: merge table, search sequencer and output queue.
//
//  channel   direction  beat                               handshake
//  s_axis    in         load entry or text byte            tvalid/tready
//  m_axis    out        token id, last flag                tvalid/tready
//  cfg       in         merge_count write                  wr_en, no wait
//
// A text beat with a byte held scans the merge table one entry per cycle through
// the RAM read port, ending early at the first matching entry.
// Reset is synchronous; the merge table is not cleared and holds garbage until loaded.
// Input beats are taken while no search is running and the output queue has room for two
// tokens, so a stalled output side holds up the input once fewer than two slots are free.
module greedy_byte_pair_tokenizer_top #(
    parameter int MERGE_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: entry_index[7:0], entry_first[15:8], entry_second[23:16], text_byte[31:24]
    input  logic [gbpt_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: kind[0]
    input  logic                              i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    // Output stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: token_id[8:0], zeros[15:9]
    output logic [gbpt_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // Configuration.
    input  logic                              i_cfg_wr_en,
    input  logic [gbpt_pkg::COUNT_W-1:0]      i_cfg_wr_data
);
    import gbpt_pkg::*;

    localparam int AW = (MERGE_ENTRIES > 1) ? $clog2(MERGE_ENTRIES) : 1;
    localparam int CW = $clog2(MERGE_ENTRIES + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state              r_state;
    t_state              n_state;
    logic [COUNT_W-1:0]  r_merge_count;
    logic [BYTE_W-1:0]   r_held_byte;
    logic                r_held_valid;
    logic [BYTE_W-1:0]   r_new_byte;
    logic                r_last;
    logic [PAIR_W-1:0]   r_key;
    logic [CW-1:0]       r_limit;
    logic [CW-1:0]       r_idx;
    logic                r_chk_valid;
    logic [AW-1:0]       r_chk_idx;

    logic                w_in_accept;
    logic                w_load;
    logic                w_text;
    logic                w_wr_en;
    logic                w_rd_en;
    logic                w_hit;
    logic                w_done;
    logic                w_room;
    logic [PAIR_W-1:0]   w_rd_data;
    logic [LW-1:0]       w_limit;
    t_push               w_push;
    t_token              w_out_tok;

    logic [BYTE_W-1:0]   w_entry_index;
    logic [BYTE_W-1:0]   w_entry_first;
    logic [BYTE_W-1:0]   w_entry_second;
    logic [BYTE_W-1:0]   w_text_byte;

    assign w_entry_index  = i_s_axis_tdata[7:0];
    assign w_entry_first  = i_s_axis_tdata[15:8];
    assign w_entry_second = i_s_axis_tdata[23:16];
    assign w_text_byte    = i_s_axis_tdata[31:24];

    // Input handshake.
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_room;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = w_in_accept && (i_s_axis_tuser == KIND_LOAD);
    assign w_text          = w_in_accept && (i_s_axis_tuser == KIND_TEXT);

    // Table loads beyond the table depth are dropped.
    assign w_wr_en = w_load && ({24'd0, w_entry_index} < 32'(MERGE_ENTRIES));

    // Number of entries searched, clipped to the table depth.
    assign w_limit = (LW'(r_merge_count) > LW'(MERGE_ENTRIES)) ?
                     LW'(MERGE_ENTRIES) : LW'(r_merge_count);

    // Search pipeline: issue one read per cycle, compare the entry read last cycle.
    assign w_rd_en = (r_state == ST_SEARCH) && (r_idx < r_limit);
    assign w_hit   = r_chk_valid && (w_rd_data == r_key);
    assign w_done  = (r_state == ST_SEARCH) && (w_hit || !w_rd_en);

    gbpt_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MERGE_ENTRIES),
        .AW    (AW)
    ) u_merge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_entry_index)),
        .i_wr_data ({w_entry_first, w_entry_second}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_text && r_held_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Token pushes into the output queue.
    always_comb begin
        w_push = '0;
        unique case (r_state)
            ST_IDLE: begin
                // A lone byte that ends the text goes straight out.
                if (w_text && !r_held_valid && i_s_axis_tlast) begin
                    w_push.push0     = 1'b1;
                    w_push.tok0.id   = TOKEN_W'(w_text_byte);
                    w_push.tok0.last = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (w_done) begin
                    w_push.push0 = 1'b1;
                    if (w_hit) begin
                        w_push.tok0.id   = TOKEN_W'(r_chk_idx) + MERGE_BASE;
                        w_push.tok0.last = r_last;
                    end else begin
                        w_push.tok0.id   = TOKEN_W'(r_held_byte);
                        w_push.tok0.last = 1'b0;
                        w_push.push1     = r_last;
                        w_push.tok1.id   = TOKEN_W'(r_new_byte);
                        w_push.tok1.last = 1'b1;
                    end
                end
            end
        endcase
    end

    // Control state and held byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_merge_count <= '0;
            r_held_byte   <= '0;
            r_held_valid  <= 1'b0;
            r_chk_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_merge_count <= i_cfg_wr_data;
            end
            r_chk_valid <= w_rd_en && !w_hit;
            if (w_text && !r_held_valid && !i_s_axis_tlast) begin
                r_held_byte  <= w_text_byte;
                r_held_valid <= 1'b1;
            end
            if (w_done) begin
                if (w_hit || r_last) begin
                    r_held_valid <= 1'b0;
                end else begin
                    r_held_byte <= r_new_byte;
                end
            end
        end
    end

    // Search context and scan counters.
    always_ff @(posedge i_clk) begin
        if (w_text && r_held_valid) begin
            r_key      <= {r_held_byte, w_text_byte};
            r_new_byte <= w_text_byte;
            r_last     <= i_s_axis_tlast;
            r_limit    <= CW'(w_limit);
            r_idx      <= '0;
        end else if (w_rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
        if (w_rd_en) begin
            r_chk_idx <= r_idx[AW-1:0];
        end
    end

    gbpt_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tok   (w_out_tok)
    );

    assign o_m_axis_tdata = M_TDATA_W'(w_out_tok.id);
    assign o_m_axis_tlast = w_out_tok.last;

`ifndef NO_ASSERTIONS
    // The second token of a cycle never comes without the first.
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push1 |-> w_push.push0)
        else $error("second token pushed without the first");

    // A text byte arriving behind a held byte starts a table scan.
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_text && r_held_valid) |=> (r_state == ST_SEARCH))
        else $error("held byte did not start a search");

    // The scan index never runs past the clipped entry count.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_idx <= r_limit))
        else $error("scan index beyond the search limit");

    // Once the final token of a text is queued, nothing stays held.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_push.push0 && w_push.tok0.last) || w_push.push1) |=> !r_held_valid)
        else $error("byte still held after the last token");
`endif

endmodule

// ----- hw/rtl/gbpt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module gbpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/gbpt_out_fifo.sv -----
// Small output queue that takes up to two tokens a cycle and drives the output stream.
module gbpt_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbpt_pkg::t_push i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output gbpt_pkg::t_token o_tok
);
    import gbpt_pkg::*;

    t_token                r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr_ptr;
    logic [OUT_PTR_W-1:0]  r_rd_ptr;
    logic [OUT_CNT_W-1:0]  r_count;
    logic [OUT_PTR_W-1:0]  w_wr_ptr1;
    logic [OUT_CNT_W-1:0]  w_push_cnt;
    logic                  w_pop;

    assign w_wr_ptr1  = r_wr_ptr + OUT_PTR_W'(1);
    assign w_push_cnt = OUT_CNT_W'(i_push.push0) + OUT_CNT_W'(i_push.push1);
    assign w_pop      = o_valid && i_ready;

    // Room for a whole item's worth of tokens.
    assign o_room  = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.push1) begin
            r_mem[w_wr_ptr1] <= i_push.tok1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(w_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + w_push_cnt - OUT_CNT_W'(w_pop);
        end
    end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the greedy byte-pair tokenizer top level.
`timescale 1ns / 1ps

module testbench;
    import gbpt_pkg::*;

    localparam int MERGE_ENTRIES = 256;
    localparam int MAX_GAP       = 17;
    localparam int PHASE_ITEMS   = 120;
    // A text beat scans at most MERGE_ENTRIES entries; leave margin.
    localparam int SETTLE_CYCLES = MERGE_ENTRIES + 44;
    localparam int ALPHA_SIZE    = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SOME,
        IDLE_HEAVY
    } t_idle_mode;

    // Tracks the tokenizer state and holds the tokens still owed by the block.
    class token_scoreboard;
        logic [PAIR_W-1:0] pair_table [MERGE_ENTRIES];
        logic [COUNT_W-1:0] merge_count;
        logic [BYTE_W-1:0] held_byte;
        logic held_valid;
        t_token owed_tokens [$];
        int unsigned fail_count;

        function new();
            merge_count = '0;
            held_byte   = '0;
            held_valid  = 1'b0;
            fail_count  = 0;
            foreach (pair_table[i]) pair_table[i] = '0;
        endfunction

        function void set_merge_count(logic [COUNT_W-1:0] value);
            merge_count = value;
        endfunction

        function void owe(logic [TOKEN_W-1:0] id, logic last);
            t_token tok;
            tok.id   = id;
            tok.last = last;
            owed_tokens.push_back(tok);
        endfunction

        // Applies one accepted input beat and queues the tokens it produces.
        function void note_beat(logic kind, logic [BYTE_W-1:0] index,
                                logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second,
                                logic [BYTE_W-1:0] text_byte, logic text_last);
            int unsigned limit;
            int unsigned hit;
            logic merged;
            logic [PAIR_W-1:0] key;
            if (kind == KIND_LOAD) begin
                pair_table[index] = {first, second};
                return;
            end
            merged = 1'b0;
            hit    = 0;
            if (held_valid) begin
                limit = (merge_count > MERGE_ENTRIES) ? MERGE_ENTRIES : merge_count;
                key   = {held_byte, text_byte};
                // First matching entry wins.
                for (int j = 0; j < limit; j++) begin
                    if (!merged && pair_table[j] == key) begin
                        merged = 1'b1;
                        hit    = j;
                    end
                end
                if (merged) begin
                    owe(MERGE_BASE + TOKEN_W'(hit), text_last);
                    held_valid = 1'b0;
                    held_byte  = '0;
                end else begin
                    owe({1'b0, held_byte}, 1'b0);
                    held_byte = text_byte;
                end
            end else begin
                held_byte  = text_byte;
                held_valid = 1'b1;
            end
            // A byte left over at the end of the text goes out alone.
            if (text_last && held_valid) begin
                owe({1'b0, held_byte}, 1'b1);
                held_valid = 1'b0;
                held_byte  = '0;
            end
        endfunction

        // Compares one accepted token with the oldest one owed.
        function void check_token(logic [TOKEN_W-1:0] id, logic last);
            t_token want;
            if (owed_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected token id=%0d last=%0b", $realtime, id, last);
                return;
            end
            want = owed_tokens.pop_front();
            if (want.id !== id || want.last !== last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] token mismatch: expected id=%0d last=%0b, got id=%0d last=%0b",
                             $realtime, want.id, want.last, id, last);
            end
        endfunction

        function int pending();
            return owed_tokens.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = KIND_LOAD;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]    cfg_wr_data = '0;

    token_scoreboard sb = new();
    t_idle_mode send_mode = IDLE_SOME;
    t_idle_mode recv_mode = IDLE_SOME;
    logic [BYTE_W-1:0] alpha [ALPHA_SIZE];

    greedy_byte_pair_tokenizer_top #(
        .MERGE_ENTRIES(MERGE_ENTRIES)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap(t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:   return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // Mostly bytes from a small alphabet so that merges are frequent.
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 9) < 7)
            return alpha[$urandom_range(0, ALPHA_SIZE - 1)];
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // Drives one input beat after a random gap and waits for its handshake.
    task automatic send_beat(logic kind, logic [BYTE_W-1:0] index, logic [BYTE_W-1:0] first,
                             logic [BYTE_W-1:0] second, logic [BYTE_W-1:0] text_byte,
                             logic text_last);
        int gap;
        gap = draw_gap(send_mode);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {text_byte, second, first, index};
        s_tuser  = kind;
        s_tlast  = text_last;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_beat(kind, index, first, second, text_byte, text_last);
    endtask

    // Load beats carry random text fields, which the block ignores.
    task automatic send_load(logic [BYTE_W-1:0] index, logic [BYTE_W-1:0] first,
                             logic [BYTE_W-1:0] second);
        send_beat(KIND_LOAD, index, first, second, BYTE_W'($urandom), 1'($urandom));
    endtask

    // Text beats carry random entry fields, which the block ignores.
    task automatic send_text(logic [BYTE_W-1:0] text_byte, logic text_last);
        send_beat(KIND_TEXT, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  text_byte, text_last);
    endtask

    // Stops sending and waits until every owed token has arrived.
    task automatic drain(int settle);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.set_merge_count(value);
    endtask

    // Output side: random stalls, then one checked token per handshake.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_gap(recv_mode);
            @(negedge clk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_token(m_tdata[TOKEN_W-1:0], m_tlast);
        end
    end

    // Main stimulus sequence.
    initial begin
        int phase_counts [9] = '{256, 511, 1, 0, 257, 255, 64, 2, 384};
        foreach (alpha[i]) alpha[i] = BYTE_W'($urandom_range(1, 255));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: texts with an empty merge list, a zero byte among them.
        write_count('0);
        send_text(8'h41, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'h01, 1'b1);

        // Directed: a small table with a duplicate pair and a zero byte.
        send_load(8'd0, 8'h41, 8'h42);
        send_load(8'd1, 8'h41, 8'h42);
        send_load(8'd2, 8'hFF, 8'h01);
        send_load(8'd3, 8'h00, 8'h7F);
        send_load(8'd255, 8'h80, 8'h80);
        drain(SETTLE_CYCLES);
        write_count(COUNT_W'(4));

        send_text(8'h41, 1'b0);
        send_text(8'h42, 1'b0);
        // Merge on the final byte carries the last flag itself.
        send_text(8'h41, 1'b0);
        send_text(8'h42, 1'b1);
        // A load between two text bytes leaves the held byte alone.
        send_text(8'h41, 1'b0);
        send_load(8'd2, 8'hFF, 8'h01);
        send_text(8'h43, 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'h7F, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h01, 1'b0);
        send_text(8'h41, 1'b1);
        send_text(8'h7F, 1'b0);
        send_text(8'h7F, 1'b1);

        // Fill the whole table so that any merge count is safe to search.
        for (int i = 0; i < MERGE_ENTRIES; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_load(BYTE_W'(i), pick_byte(), pick_byte());
            else
                send_load(BYTE_W'(i), BYTE_W'($urandom_range(1, 255)),
                          BYTE_W'($urandom_range(1, 255)));
        end

        // Random phases, each with its own merge count and idle pattern.
        foreach (phase_counts[p]) begin
            drain(SETTLE_CYCLES);
            write_count(COUNT_W'(phase_counts[p]));
            if (p == 0) begin
                send_mode = IDLE_HEAVY;
                recv_mode = IDLE_HEAVY;
            end else if (p == 1) begin
                send_mode = IDLE_NONE;
                recv_mode = IDLE_NONE;
            end else begin
                send_mode = t_idle_mode'($urandom_range(0, 2));
                recv_mode = t_idle_mode'($urandom_range(0, 2));
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == PHASE_ITEMS / 2)
                    drain(0);
                if ($urandom_range(0, 99) < 15)
                    send_load(BYTE_W'($urandom_range(0, 255)), pick_byte(), pick_byte());
                else
                    send_text(pick_byte(), $urandom_range(0, 7) == 0);
            end
        end

        drain(SETTLE_CYCLES);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
